// ===== sv/teq_pkg.sv =====
// Shared types and constants for the tunnel entry/exit qualifier.
// Used by teq_lane, teq_merge and tunnel_entry_exit_qualifier; no dependencies.
package teq_pkg;

    localparam int DIST_W      = 16;
    localparam int THRESH_W    = 15;
    localparam int CAMCNT_W    = 2;
    localparam int LANES       = 2;
    localparam int HISTORY_DEF = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERAS   = 1'd1;

    localparam logic [THRESH_W-1:0] THRESHOLD_RST = 15'd2560;
    localparam logic [CAMCNT_W-1:0] CAMERAS_RST   = 2'd2;
    localparam logic [CAMCNT_W-1:0] CAMERAS_TWO   = 2'd2;

    // A reading at or below -0.5 (Q8.8) means the vehicle is out.
    localparam logic signed [DIST_W-1:0] DIST_FLOOR = -16'sd128;

    // Qualified tunnel state codes.
    localparam int STATE_W = 2;
    localparam logic [STATE_W-1:0] ST_OUT   = 2'd0;
    localparam logic [STATE_W-1:0] ST_PREIN = 2'd1;
    localparam logic [STATE_W-1:0] ST_IN    = 2'd2;

    // What one lane finds about one reading.
    typedef struct packed {
        logic above_floor;   // reading > -0.5
        logic below_th;      // reading < threshold
        logic nonneg;        // reading >= 0
    } lane_flags_t;

endpackage

// ===== sv/tunnel_entry_exit_qualifier.sv =====
// Top level of the tunnel entry/exit qualifier: stream ports, configuration
// registers, history register, state machine and output register.
// Depends on teq_pkg, teq_lane and teq_merge.
//
// Usage:
//   Each input word on the s_axis channel carries two signed Q8.8 camera
//   distances. Two comparison lanes check each reading against the floor of
//   -0.5 and the configured threshold; a merging stage adds the sum test and
//   picks one- or two-camera mode. The instant result shifts into a history
//   register and drives the outside / pre-entry / inside state machine.
//   Each accepted word yields exactly one output word on m_axis holding the
//   qualified state and the instant classification.
//   m_axis_tvalid rises in the cycle after a word is accepted. Throughput is one
//   word per cycle; the only stored stage is the output register, so a new
//   word is accepted whenever that register is empty or being drained.
//   When the receiver stalls, the output word holds and s_axis_tready drops
//   until it is taken. Reset clears the history to all outside, the state to
//   outside, the threshold to 10.0 and the camera count to two; no output
//   word is pending after reset. The user writes configuration via cfg_we,
//   cfg_index and cfg_wdata only while the block is idle; it is not enforced.
module tunnel_entry_exit_qualifier
#(
    parameter int HISTORY_LEN = teq_pkg::HISTORY_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: [15:0] dist_first, [31:16] dist_second
    input  logic [31:0]                      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: [1:0] tunnel_state, [2] instant_in, [7:3] zero
    output logic [7:0]                       m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [teq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [teq_pkg::THRESH_W-1:0]     cfg_wdata
);

    logic [teq_pkg::THRESH_W-1:0] threshold_reg;
    logic [teq_pkg::CAMCNT_W-1:0] cameras_reg;
    logic [HISTORY_LEN-1:0]       hist_reg;
    logic [HISTORY_LEN-1:0]       hist_next;
    logic [teq_pkg::STATE_W-1:0]  mode_reg;
    logic [teq_pkg::STATE_W-1:0]  mode_next;
    logic                         out_valid_reg;
    logic [teq_pkg::STATE_W-1:0]  out_state_reg;
    logic                         out_instant_reg;

    logic signed [teq_pkg::DIST_W-1:0] reading [teq_pkg::LANES];
    teq_pkg::lane_flags_t              lane_flags [teq_pkg::LANES];
    logic                              now_in;
    logic                              accept;

    assign reading[0] = $signed(s_axis_tdata[15:0]);
    assign reading[1] = $signed(s_axis_tdata[31:16]);

    // One comparison lane per camera reading.
    for (genvar g = 0; g < teq_pkg::LANES; g++)
    begin : g_lane
        teq_lane u_lane
        (
            .reading   (reading[g]),
            .threshold (threshold_reg),
            .flags     (lane_flags[g])
        );
    end

    teq_merge u_merge
    (
        .flags_first  (lane_flags[0]),
        .flags_second (lane_flags[1]),
        .dist_first   (reading[0]),
        .dist_second  (reading[1]),
        .threshold    (threshold_reg),
        .camera_count (cameras_reg),
        .now_in       (now_in)
    );

    // The output register parts the two sides; it can take a new word when it
    // is empty or is being drained in this cycle.
    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign accept        = s_axis_tvalid & s_axis_tready;

    assign hist_next = {hist_reg[HISTORY_LEN-2:0], now_in};

    // Qualification state machine. Entry needs a full history of in, exit
    // from inside needs a full history of out. The unused code holds.
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            teq_pkg::ST_OUT:
            begin
                if (now_in)
                begin
                    mode_next = teq_pkg::ST_PREIN;
                end
            end
            teq_pkg::ST_PREIN:
            begin
                if (!now_in)
                begin
                    mode_next = teq_pkg::ST_OUT;
                end
                else if (&hist_next)
                begin
                    mode_next = teq_pkg::ST_IN;
                end
            end
            teq_pkg::ST_IN:
            begin
                if (!now_in && !(|hist_next))
                begin
                    mode_next = teq_pkg::ST_OUT;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= teq_pkg::THRESHOLD_RST;
            cameras_reg   <= teq_pkg::CAMERAS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                teq_pkg::REG_THRESHOLD:
                begin
                    threshold_reg <= cfg_wdata;
                end
                teq_pkg::REG_CAMERAS:
                begin
                    cameras_reg <= cfg_wdata[teq_pkg::CAMCNT_W-1:0];
                end
                default:
                begin
                    threshold_reg <= threshold_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= '0;
            mode_reg      <= teq_pkg::ST_OUT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                hist_reg      <= hist_next;
                mode_reg      <= mode_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output register needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_state_reg   <= mode_next;
            out_instant_reg <= now_in;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_instant_reg, out_state_reg};

    // A pending result always reflects the newest history bit and state.
    a_instant_matches_history: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2] == hist_reg[0]))
        else $error("output instant bit differs from newest history bit");

    a_state_matches_mode: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == mode_reg))
        else $error("output state differs from qualified state");

    // Inside is entered only from pre-entry with a history of all in.
    a_inside_needs_full_history: assert property (
        @(posedge clk) disable iff (!rst_n)
        (mode_reg != teq_pkg::ST_IN) ##1 (mode_reg == teq_pkg::ST_IN)
            |-> ((&hist_reg) && ($past(mode_reg) == teq_pkg::ST_PREIN)))
        else $error("inside state entered without a full history");

endmodule

// ===== sv/teq_lane.sv =====
// One comparison lane: qualifies a single Q8.8 distance reading.
// Depends on teq_pkg.
module teq_lane
(
    input  logic signed [teq_pkg::DIST_W-1:0]   reading,
    input  logic        [teq_pkg::THRESH_W-1:0] threshold,
    output teq_pkg::lane_flags_t                flags
);

    logic signed [teq_pkg::DIST_W:0] dist_ext;
    logic signed [teq_pkg::DIST_W:0] th_ext;

    assign dist_ext = {reading[teq_pkg::DIST_W-1], reading};
    assign th_ext   = $signed({2'b00, threshold});

    always_comb
    begin
        flags.above_floor = (reading > teq_pkg::DIST_FLOOR);
        flags.below_th    = (dist_ext < th_ext);
        flags.nonneg      = ~reading[teq_pkg::DIST_W-1];
    end

endmodule

// ===== sv/teq_merge.sv =====
// Merging stage: combines the lane flags and the sum test into one
// instant in/out decision. Depends on teq_pkg.
module teq_merge
(
    input  teq_pkg::lane_flags_t                flags_first,
    input  teq_pkg::lane_flags_t                flags_second,
    input  logic signed [teq_pkg::DIST_W-1:0]   dist_first,
    input  logic signed [teq_pkg::DIST_W-1:0]   dist_second,
    input  logic        [teq_pkg::THRESH_W-1:0] threshold,
    input  logic        [teq_pkg::CAMCNT_W-1:0] camera_count,
    output logic                                now_in
);

    logic signed [teq_pkg::DIST_W:0]   sum;
    logic signed [teq_pkg::DIST_W+1:0] sum_ext;
    logic signed [teq_pkg::DIST_W+1:0] twice_th;
    logic                              two_in;
    logic                              one_in;

    assign sum      = {dist_first[teq_pkg::DIST_W-1], dist_first}
                    + {dist_second[teq_pkg::DIST_W-1], dist_second};
    assign sum_ext  = {sum[teq_pkg::DIST_W], sum};
    assign twice_th = $signed({2'b00, threshold, 1'b0});

    always_comb
    begin
        two_in = flags_first.above_floor && flags_second.above_floor &&
                 ((flags_first.below_th && flags_second.below_th) ||
                  (sum_ext < twice_th));
        one_in = flags_first.nonneg && flags_first.below_th;
        now_in = (camera_count == teq_pkg::CAMERAS_TWO) ? two_in : one_in;
    end

endmodule

// ===== bench/tb_tunnel_entry_exit_qualifier.sv =====
// Self-checking testbench for tunnel_entry_exit_qualifier: directed table, then random
// phases under changing threshold and camera settings, each word checked against a predictor.
// Depends on teq_pkg and the RTL of tunnel_entry_exit_qualifier.
`timescale 1ns / 100ps

module tb_tunnel_entry_exit_qualifier;

    localparam int HIST_LEN        = teq_pkg::HISTORY_DEF;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 200;
    localparam int MAX_PRINTED     = 50;

    // One output word as the checker sees it.
    typedef struct packed {
        logic [teq_pkg::STATE_W-1:0] zone;
        logic                        instant;
    } verdict_t;

    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

    // One row of the directed table: either a register setting or a word
    // whose result can be read off at a glance.
    typedef struct packed {
        row_kind_e                    kind;
        logic [teq_pkg::DIST_W-1:0]   d0;
        logic [teq_pkg::DIST_W-1:0]   d1;
        logic [teq_pkg::THRESH_W-1:0] thr;
        logic [teq_pkg::CAMCNT_W-1:0] cams;
        verdict_t                     want;
    } plan_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [31:0]                    s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [7:0]                     m_axis_tdata;
    logic                           cfg_we;
    logic [teq_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [teq_pkg::THRESH_W-1:0]   cfg_wdata;

    // Shadow copy of the block: its registers, history and qualified state.
    logic [teq_pkg::THRESH_W-1:0]   thr_setting;
    logic [teq_pkg::CAMCNT_W-1:0]   cam_setting;
    logic [HIST_LEN-1:0]            hist_bits;
    logic [teq_pkg::STATE_W-1:0]    zone_q;

    // Results predicted for accepted words, oldest first.
    verdict_t pending_verdicts[$];

    int  err_count    = 0;
    int  words_sent   = 0;
    int  results_seen = 0;
    int  cfg_writes   = 0;
    int  cycle_cnt    = 0;
    int  zone_hits[4] = '{0, 0, 0, 0};
    bit  sender_steady = 1'b0;
    bit  sink_steady   = 1'b0;

    tunnel_entry_exit_qualifier #(
        .HISTORY_LEN (HIST_LEN)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] dist_first, [31:16] dist_second
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [1:0] tunnel_state, [2] instant_in, [7:3] zero
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_tunnel_entry_exit_qualifier NOT OK");
            $finish;
        end
    end

    task automatic report(string what);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Instant classification under the current threshold and camera count.
    // Everything is done in plain ints, so the two-camera sum cannot wrap.
    function automatic bit pair_reads_inside(logic signed [teq_pkg::DIST_W-1:0] a,
                                             logic signed [teq_pkg::DIST_W-1:0] b);
        int ia;
        int ib;
        int th;
        ia = a;
        ib = b;
        th = int'(thr_setting);
        if (cam_setting == teq_pkg::CAMERAS_TWO)
        begin
            if (ia <= int'(teq_pkg::DIST_FLOOR) || ib <= int'(teq_pkg::DIST_FLOOR))
                return 1'b0;
            if (ia < th && ib < th)
                return 1'b1;
            return (ia + ib) < 2 * th;
        end
        // Camera counts 0, 1 and 3 all fall back to the first reading alone.
        return ia >= 0 && ia < th;
    endfunction

    // Advances the shadow history and state machine by one word and returns
    // the output word the block must produce for it.
    function automatic verdict_t qualify_word(logic [teq_pkg::DIST_W-1:0] a,
                                              logic [teq_pkg::DIST_W-1:0] b);
        verdict_t v;
        logic     now_in;
        now_in    = pair_reads_inside(a, b);
        hist_bits = {hist_bits[HIST_LEN-2:0], now_in};
        case (zone_q)
            teq_pkg::ST_OUT:
                if (now_in)
                    zone_q = teq_pkg::ST_PREIN;
            teq_pkg::ST_PREIN:
                if (!now_in)
                    zone_q = teq_pkg::ST_OUT;
                else if (&hist_bits)
                    zone_q = teq_pkg::ST_IN;
            teq_pkg::ST_IN:
                if (!now_in && hist_bits == '0)
                    zone_q = teq_pkg::ST_OUT;
            default:
                ;   // the unused code would simply be held
        endcase
        v.zone    = zone_q;
        v.instant = now_in;
        return v;
    endfunction

    function automatic plan_row_t word_row(int a, int b, logic [teq_pkg::STATE_W-1:0] zone,
                                           logic is_in);
        plan_row_t r;
        r              = '0;
        r.kind         = ROW_WORD;
        r.d0           = 16'(a);
        r.d1           = 16'(b);
        r.want.zone    = zone;
        r.want.instant = is_in;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(int thr, logic [teq_pkg::CAMCNT_W-1:0] cams);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.thr  = 15'(thr);
        r.cams = cams;
        return r;
    endfunction

    // A reading meant to classify in (or out) under the current settings.
    // In one-camera mode with a zero threshold nothing is in, so any value goes.
    function automatic logic [teq_pkg::DIST_W-1:0] reading_for(bit want_in);
        int th;
        th = int'(thr_setting);
        if (want_in)
        begin
            if (cam_setting == teq_pkg::CAMERAS_TWO)
                return 16'(int'($urandom_range(0, th + 126)) - 127);
            if (th > 0)
                return 16'($urandom_range(0, th - 1));
            return 16'($urandom);
        end
        if ($urandom_range(0, 1) == 1)
            return 16'($urandom_range(th, 32767));
        return 16'(-128 - int'($urandom_range(0, 32640)));
    endfunction

    // Readings near the edges of the compares, or anything at all.
    function automatic logic [teq_pkg::DIST_W-1:0] noise_reading();
        int th;
        th = int'(thr_setting);
        case ($urandom_range(0, 5))
            0:       return 16'(th - 1);
            1:       return 16'(th);
            2:       return 16'(th + 1);
            3:       return teq_pkg::DIST_FLOOR + 16'($urandom_range(0, 1));
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one word after a random gap and waits for it to be taken. The
    // expected result is queued at the accepting edge; a typed expectation from
    // the directed table replaces the predicted one, but the predictor still
    // steps so that its state follows the block.
    task automatic send_word(logic [teq_pkg::DIST_W-1:0] a, logic [teq_pkg::DIST_W-1:0] b,
                             bit typed, verdict_t want);
        int       gap;
        verdict_t v;
        gap = sender_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
        v = qualify_word(a, b);
        pending_verdicts.push_back(typed ? want : v);
    endtask

    // Stops offering words until every expected result has come back, then
    // lets the output stage settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes both registers on back-to-back edges. The camera count goes
    // out with junk in the unused upper bits, which the block must drop.
    task automatic write_cfg(logic [teq_pkg::THRESH_W-1:0] thr,
                             logic [teq_pkg::CAMCNT_W-1:0] cams);
        cfg_we    <= 1'b1;
        cfg_index <= teq_pkg::REG_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_index <= teq_pkg::REG_CAMERAS;
        cfg_wdata <= {13'($urandom), cams};
        @(posedge clk);
        cfg_we      <= 1'b0;
        thr_setting  = thr;
        cam_setting  = cams;
        cfg_writes++;
    endtask

    // Receiver: random back-pressure, with calm stretches where it always
    // takes the word, and an in-order check of each word that leaves.
    initial
    begin
        verdict_t got;
        verdict_t want;
        int       gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_seen % 50 == 0)
                sink_steady = ($urandom_range(0, 3) == 0);
            gap = sink_steady ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            got.zone    = m_axis_tdata[1:0];
            got.instant = m_axis_tdata[2];
            results_seen++;
            if (!$isunknown(got.zone))
                zone_hits[got.zone]++;
            if (pending_verdicts.size() == 0)
            begin
                report($sformatf("unexpected word state=%0d instant=%0d",
                                 got.zone, got.instant));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.zone !== want.zone)
                    report($sformatf("result %0d: state %0d, expected %0d",
                                     results_seen, got.zone, want.zone));
                if (got.instant !== want.instant)
                    report($sformatf("result %0d: instant %0d, expected %0d",
                                     results_seen, got.instant, want.instant));
            end
        end
    end

    // Sender and sequencing of the whole run.
    initial
    begin
        plan_row_t                    plan[$];
        logic [teq_pkg::DIST_W-1:0]   a;
        logic [teq_pkg::DIST_W-1:0]   b;
        logic [teq_pkg::THRESH_W-1:0] thr;
        logic [teq_pkg::CAMCNT_W-1:0] cams;
        int                           run_left;
        int                           k;
        bit                           run_in;
        bit                           noisy;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = teq_pkg::REG_THRESHOLD;
        cfg_wdata     = '0;
        rst_n         = 1'b0;
        thr_setting   = teq_pkg::THRESHOLD_RST;
        cam_setting   = teq_pkg::CAMERAS_RST;
        hist_bits     = '0;
        zone_q        = teq_pkg::ST_OUT;
        run_left      = 0;
        run_in        = 1'b0;
        noisy         = 1'b0;

        // Directed table. The reset settings come first: a reading exactly at
        // the -0.5 floor, the field extremes, and the sum test on both sides of
        // twice the threshold. At most two ins come in a row, so the history
        // never fills and the state only moves between outside and pre-entry.
        plan.push_back(word_row(0, 0, teq_pkg::ST_PREIN, 1'b1));
        plan.push_back(word_row(0, -128, teq_pkg::ST_OUT, 1'b0));
        plan.push_back(word_row(-127, -127, teq_pkg::ST_PREIN, 1'b1));
        plan.push_back(word_row(32767, -32768, teq_pkg::ST_OUT, 1'b0));
        plan.push_back(word_row(2559, 2559, teq_pkg::ST_PREIN, 1'b1));
        plan.push_back(word_row(2560, 2559, teq_pkg::ST_PREIN, 1'b1));
        plan.push_back(word_row(2560, 2560, teq_pkg::ST_OUT, 1'b0));
        // One-camera mode, including the camera counts that only fall back to
        // it; the second reading must be ignored.
        plan.push_back(cfg_row(2560, 2'd1));
        plan.push_back(word_row(0, -32768, teq_pkg::ST_PREIN, 1'b1));
        plan.push_back(word_row(-1, 0, teq_pkg::ST_OUT, 1'b0));
        plan.push_back(cfg_row(2560, 2'd0));
        plan.push_back(word_row(2559, -32768, teq_pkg::ST_PREIN, 1'b1));
        plan.push_back(cfg_row(2560, 2'd3));
        plan.push_back(word_row(2560, 0, teq_pkg::ST_OUT, 1'b0));
        // A zero threshold: above the floor, a pair is in only if both or its sum are negative.
        plan.push_back(cfg_row(0, teq_pkg::CAMERAS_TWO));
        plan.push_back(word_row(0, 0, teq_pkg::ST_OUT, 1'b0));
        plan.push_back(word_row(-1, -1, teq_pkg::ST_PREIN, 1'b1));
        // The largest threshold in both modes; the two-camera sum goes past
        // sixteen bits here.
        plan.push_back(cfg_row(32767, 2'd1));
        plan.push_back(word_row(32766, 0, teq_pkg::ST_PREIN, 1'b1));
        plan.push_back(word_row(32767, 0, teq_pkg::ST_OUT, 1'b0));
        plan.push_back(cfg_row(32767, teq_pkg::CAMERAS_TWO));
        plan.push_back(word_row(32767, 32766, teq_pkg::ST_PREIN, 1'b1));
        plan.push_back(word_row(-32768, -32768, teq_pkg::ST_OUT, 1'b0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain();
                write_cfg(plan[i].thr, plan[i].cams);
            end
            else
            begin
                send_word(plan[i].d0, plan[i].d1, 1'b1, plan[i].want);
            end
        end

        // Random phases, each under its own settings. Most words come in runs
        // of the same intended class, often long enough to fill or empty the
        // history so that the inside state is entered and left; the rest are
        // short bursts of edge values and arbitrary readings.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    thr  = teq_pkg::THRESHOLD_RST;
                    cams = teq_pkg::CAMERAS_TWO;
                end
                1:       begin thr = '0;                           cams = teq_pkg::CAMERAS_TWO; end
                2:       begin thr = '1;                           cams = teq_pkg::CAMERAS_TWO; end
                3:       begin thr = 15'($urandom);                cams = teq_pkg::CAMERAS_TWO; end
                4:       begin thr = 15'($urandom_range(1, 1024)); cams = 2'd1;                 end
                5:       begin thr = '0;                           cams = 2'd1;                 end
                6:       begin thr = '1;                           cams = 2'd0;                 end
                default: begin thr = 15'($urandom);                cams = 2'd3;                 end
            endcase
            drain();
            write_cfg(thr, cams);

            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (n % 40 == 0)
                    sender_steady = ($urandom_range(0, 3) == 0);
                // Hold off mid-phase until the block has returned everything.
                if (phase == 3 && n == WORDS_PER_PHASE / 2)
                    drain();

                if (run_left == 0)
                begin
                    noisy = ($urandom_range(0, 4) == 0);
                    if (noisy)
                    begin
                        run_left = $urandom_range(1, 6);
                    end
                    else
                    begin
                        run_in   = !run_in;
                        run_left = $urandom_range(1, 12);
                    end
                end
                run_left--;

                if (!noisy)
                begin
                    a = reading_for(run_in);
                    b = reading_for(run_in);
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    // Pair whose sum lands on or just under twice the threshold.
                    k = $urandom_range(0, 3);
                    a = 16'(int'(thr_setting) + k);
                    b = 16'(int'(thr_setting) - k - int'($urandom_range(0, 1)));
                end
                else
                begin
                    a = noise_reading();
                    b = noise_reading();
                end
                send_word(a, b, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Sent %0d words and checked %0d results across %0d register settings.",
                 words_sent, results_seen, cfg_writes);
        $display("States returned: outside %0d, pre-entry %0d, inside %0d.",
                 zone_hits[0], zone_hits[1], zone_hits[2]);
        if (err_count == 0)
            $display("tb_tunnel_entry_exit_qualifier OK");
        else
            $display("tb_tunnel_entry_exit_qualifier NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/teq_pkg.sv
sv/teq_lane.sv
sv/teq_merge.sv
sv/tunnel_entry_exit_qualifier.sv
bench/tb_tunnel_entry_exit_qualifier.sv
